@@ sv/ilid_pkg.sv @@
// ilid_pkg: shared types and codes for the indexed list insert/delete core
// beat structs for both channels, opcode and status codes, cell control bundle
// no dependencies
`default_nettype none

package ilid_pkg;

  // widest position the cell chain ever needs (capacity up to 1024)
  localparam int POS_W = 11;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_HEAD   = 3'd1;
  localparam logic [2:0] OP_TAIL   = 3'd2;
  localparam logic [2:0] OP_AT     = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [15:0] position;
    logic signed [31:0] data_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         length;
  } rsp_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE
  } cell_cmd_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    cell_cmd_t          cmd;
    logic [POS_W-1:0]   pos;
    logic signed [31:0] word;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/ilid_cell.sv @@
// ilid_cell: one storage cell of the list chain
// holds one word, shifts from its left or right neighbor on insert/delete
// depends on ilid_pkg
`default_nettype none

module ilid_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  ilid_pkg::cell_ctl_t ctl,
  input  logic signed [31:0]  left_word,
  input  logic signed [31:0]  right_word,
  output logic signed [31:0]  word,
  output logic signed [31:0]  rd_word
);
  import ilid_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic signed [31:0] word_next;

  always_comb begin
    word_next = word;
    unique case (ctl.cmd)
      CMD_HOLD: begin
        word_next = word;
      end
      CMD_INSERT: begin
        if (MY_IDX == ctl.pos) begin
          word_next = ctl.word;
        end else if (MY_IDX > ctl.pos) begin
          word_next = left_word;
        end
      end
      CMD_DELETE: begin
        if (MY_IDX >= ctl.pos) begin
          word_next = right_word;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // contribution to the and-or read bus
  assign rd_word = (MY_IDX == ctl.pos) ? word : '0;

endmodule

`default_nettype wire

@@ sv/indexed_list_insert_delete_core.sv @@
// indexed_list_insert_delete_core: ordered list of signed words in a chain of cells
// decodes each request beat, drives the cell chain, registers one response beat
// depends on ilid_pkg, ilid_cell
//
//   channel | direction | handshake           | beat
//   --------+-----------+---------------------+-----------------------------------
//   req     | in        | req_valid/req_stall | opcode, position, data_value
//   rsp     | out       | rsp_valid/rsp_stall | read_value, status, length
//
// one request beat per cycle unless stalled; its response beat shows in the next cycle
// every cell decides in the accept cycle whether to hold, take its neighbor or
// take the new word, so insert and delete shift the whole list at the accepting edge
// the response register parts the two sides; req_stall is high only while a
// response beat waits and rsp_stall holds it
// reset clears the entry count and the response valid; cell contents are not reset
`default_nettype none

module indexed_list_insert_delete_core #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ilid_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ilid_pkg::rsp_t rsp
);
  import ilid_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // entry count
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic req_accept;

  // decode results
  cell_ctl_t          ctl;
  logic [1:0]         status;
  logic               is_read_hit;
  logic [14:0]        pos_mag;
  logic               pos_neg;
  logic [14:0]        count_ext;
  logic [15:0]        len_wide;

  // chain wiring
  logic signed [31:0] cell_word [CAPACITY];
  logic signed [31:0] cell_rd   [CAPACITY];
  logic signed [31:0] rd_bus;

  rsp_t rsp_next;

  assign req_stall  = rsp_valid && rsp_stall;
  assign req_accept = req_valid && !req_stall;

  assign pos_neg   = req.position[15];
  assign pos_mag   = req.position[14:0];
  assign count_ext = 15'(count);

  // decode the request into a chain command and a status
  always_comb begin
    ctl.cmd     = CMD_HOLD;
    ctl.pos     = POS_W'(pos_mag);
    ctl.word    = req.data_value;
    status      = ST_RANGE;
    is_read_hit = 1'b0;
    count_next  = count;
    unique case (req.opcode) inside
      OP_READ: begin
        if (!pos_neg && (pos_mag < count_ext)) begin
          status      = ST_DONE;
          is_read_hit = 1'b1;
        end
      end
      OP_HEAD, OP_TAIL, OP_AT: begin
        if (req.opcode == OP_HEAD) begin
          ctl.pos = '0;
          status  = ST_DONE;
        end else if (req.opcode == OP_TAIL) begin
          ctl.pos = POS_W'(count);
          status  = ST_DONE;
        end else if (pos_neg) begin
          // negative position clamps to the head
          ctl.pos = '0;
          status  = ST_DONE;
        end else if (pos_mag <= count_ext) begin
          status = ST_DONE;
        end
        // past-the-end check wins over the full check
        if ((status == ST_DONE) && (count == CAP_CNT)) begin
          status = ST_FULL;
        end
        if (status == ST_DONE) begin
          ctl.cmd    = CMD_INSERT;
          count_next = count + 1'b1;
        end
      end
      OP_DELETE: begin
        if (!pos_neg && (pos_mag < count_ext)) begin
          status     = ST_DONE;
          ctl.cmd    = CMD_DELETE;
          count_next = count - 1'b1;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
    // the chain only moves on an accepted beat
    if (!req_accept) begin
      ctl.cmd = CMD_HOLD;
    end
  end

  // the cell chain: each cell sees its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_w;
    logic signed [31:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_word[i];
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    ilid_cell #(
      .IDX(i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_word (left_w),
      .right_word(right_w),
      .word      (cell_word[i]),
      .rd_word   (cell_rd[i])
    );
  end

  // at most one cell matches the position, so the read bus is a plain or
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // length is reported in seven bits
  assign len_wide = 16'(count_next);

  always_comb begin
    rsp_next.read_value = is_read_hit ? rd_bus : '0;
    rsp_next.status     = status;
    rsp_next.length     = len_wide[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload, no reset
  always_ff @(posedge clk) begin
    if (req_accept) begin
      rsp <= rsp_next;
    end
  end

  // count never runs past capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  // a waiting response always carries the current length
  a_rsp_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.length == 7'(count)))
    else $error("response length out of step with entry count");

  // count only moves with an accepted beat
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !req_accept |=> (count == $past(count)))
    else $error("entry count changed without a request beat");

  // a failed operation always returns a zero read value
  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_DONE)) |-> (rsp.read_value == '0))
    else $error("nonzero read value on a failed operation");

  // an accepted beat always produces a response
  a_rsp_after: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> rsp_valid)
    else $error("request beat without response");

endmodule

`default_nettype wire

@@ bench/ilid_list_checker.sv @@
`timescale 1ns / 100ps
// ilid_list_checker: watches the request and response channels of the list core,
// keeps its own copy of the list, and compares each response beat field by field
// depends on ilid_pkg
module ilid_list_checker #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  ilid_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  ilid_pkg::rsp_t rsp,
  output int             mismatches,
  output int             awaited,
  output int             held_length,
  output int             full_rejects,
  output int             beats_checked
);
  import ilid_pkg::*;

  logic signed [31:0] held_words[$];
  rsp_t               awaited_rsp[$];
  rsp_t               want;

  function automatic logic [1:0] insert_word(int at, logic signed [31:0] word);
    if (at < 0) at = 0;
    // past-the-end is tested before full
    if (at > held_words.size()) return ST_RANGE;
    if (held_words.size() >= CAPACITY) return ST_FULL;
    held_words.insert(at, word);
    return ST_DONE;
  endfunction

  function automatic rsp_t apply_list_op(req_t beat);
    int   at;
    rsp_t result;
    at = $signed(beat.position);
    result = '0;
    result.status = ST_RANGE;
    case (beat.opcode)
      OP_READ: begin
        if (at >= 0 && at < held_words.size()) begin
          result.read_value = held_words[at];
          result.status = ST_DONE;
        end
      end
      OP_HEAD:   result.status = insert_word(0, beat.data_value);
      OP_TAIL:   result.status = insert_word(held_words.size(), beat.data_value);
      OP_AT:     result.status = insert_word(at, beat.data_value);
      OP_DELETE: begin
        if (at >= 0 && at < held_words.size()) begin
          held_words.delete(at);
          result.status = ST_DONE;
        end
      end
      default: ;
    endcase
    result.length = 7'(held_words.size());
    return result;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= 20)
      $display("[%0t] mismatch on response beat %0d, %s: got %0h, want %0h",
               $time, beats_checked, field, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_words.delete();
      awaited_rsp.delete();
    end else begin
      if (req_valid && !req_stall) awaited_rsp.push_back(apply_list_op(req));
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("beat with none awaited", rsp.read_value, '0);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.read_value !== want.read_value)
            report_mismatch("read_value", rsp.read_value, want.read_value);
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.length !== want.length)
            report_mismatch("length", 32'(rsp.length), 32'(want.length));
          if (want.status == ST_FULL) full_rejects++;
          beats_checked++;
        end
      end
    end
    awaited = awaited_rsp.size();
    held_length = held_words.size();
  end

endmodule

@@ bench/indexed_list_insert_delete_core_test.sv @@
`timescale 1ns / 100ps
// indexed_list_insert_delete_core_test: drives request beats into the list core and
// throttles its response side; the checker beside the core predicts and compares
// depends on ilid_pkg, ilid_list_checker, indexed_list_insert_delete_core
module indexed_list_insert_delete_core_test;
  import ilid_pkg::*;

  localparam int CAPACITY         = 64;
  localparam int RESET_CYCLES     = 10;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int BLOCK_BEATS      = 60;
  localparam int PRESSURE_BEATS   = 30;
  localparam int CYCLE_LIMIT      = 200000;
  // opcodes the core does not use
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // which way a block of random beats pushes the list length
  typedef enum {LEAN_GROW, LEAN_SHRINK, LEAN_MIX} lean_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int mismatches, awaited, held_length, full_rejects, beats_checked;
  int cycle_count = 0;
  // sender gap rate: 0 means back to back, else one gap in n beats
  int sender_odds = 0;
  // handshake flag between the stimulus and the response side
  bit long_hold_req = 1'b0;
  // last stretch of the run: no idling on either side
  bit quiet_tail = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  indexed_list_insert_delete_core #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  ilid_list_checker #(
    .CAPACITY(CAPACITY)
  ) list_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .mismatches   (mismatches),
    .awaited      (awaited),
    .held_length  (held_length),
    .full_rejects (full_rejects),
    .beats_checked(beats_checked)
  );

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d beats still awaited",
               cycle_count, awaited);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // response side: random stall bursts, one long hold on request, calm at the end
  initial begin : drain_side
    int odds;
    int window;
    odds = 0;
    window = 0;
    do @(posedge clk); while (rst);
    forever begin
      // pick a fresh stall rate each time the window runs out, sometimes none at all
      if (window == 0) begin
        window = 48;
        case ($urandom_range(0, 2))
          0:       odds = 0;
          1:       odds = 6;
          default: odds = 3;
        endcase
      end
      window--;
      if (long_hold_req) begin
        // long hold so the response register fills and the core stalls its input
        long_hold_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (!quiet_tail && odds != 0 && $urandom_range(1, odds) == 1) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  function automatic req_t make_beat(logic [2:0] op, int at, int word);
    req_t beat;
    beat.opcode = op;
    beat.position = at[15:0];
    beat.data_value = word;
    return beat;
  endfunction

  // mostly in-range positions, plus the edges and the odd wild value
  function automatic int aim_position(int len);
    case ($urandom_range(0, 9))
      0:       return int'($signed(16'($urandom)));
      1:       return len;
      2:       return len + 1;
      3:       return -1;
      default: return (len > 0) ? int'($urandom_range(0, len - 1)) : 0;
    endcase
  endfunction

  function automatic req_t random_beat(lean_t lean, int len);
    int         roll;
    int         cut_read, cut_head, cut_tail, cut_at;
    logic [2:0] op;
    roll = $urandom_range(0, 99);
    case (lean)
      LEAN_GROW: begin
        cut_read = 10; cut_head = 25; cut_tail = 45; cut_at = 85;
      end
      LEAN_SHRINK: begin
        cut_read = 15; cut_head = 20; cut_tail = 25; cut_at = 35;
      end
      default: begin
        cut_read = 25; cut_head = 37; cut_tail = 49; cut_at = 69;
      end
    endcase
    if (roll < cut_read)      op = OP_READ;
    else if (roll < cut_head) op = OP_HEAD;
    else if (roll < cut_tail) op = OP_TAIL;
    else if (roll < cut_at)   op = OP_AT;
    else if (roll < 98)       op = OP_DELETE;
    else                      op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    return make_beat(op, aim_position(len), $urandom);
  endfunction

  // hold the beat until the core takes it
  task automatic send_beat(req_t beat);
    req <= beat;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // random sender gap; payload wanders while valid is low
  task automatic maybe_gap();
    logic [63:0] noise;
    if (sender_odds != 0 && $urandom_range(1, sender_odds) == 1) begin
      noise = {$urandom, $urandom};
      req_valid <= 1'b0;
      req <= noise[$bits(req_t)-1:0];
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // stop offering beats until every predicted response has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  initial begin : stimulus
    lean_t plan [0:11];
    plan = '{LEAN_GROW, LEAN_GROW, LEAN_MIX, LEAN_SHRINK, LEAN_SHRINK, LEAN_GROW,
             LEAN_GROW, LEAN_GROW, LEAN_MIX, LEAN_SHRINK, LEAN_GROW, LEAN_MIX};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list: read, delete and insert past the end all bounce
    send_beat(make_beat(OP_READ, 0, 0));
    send_beat(make_beat(OP_DELETE, 0, 0));
    send_beat(make_beat(OP_AT, 1, 32'h0BAD_0BAD));
    // most negative position clamps to the head
    send_beat(make_beat(OP_AT, -32768, 32'h8000_0000));
    send_beat(make_beat(OP_HEAD, 0, 32'h7FFF_FFFF));
    send_beat(make_beat(OP_TAIL, 0, -1));
    // insert exactly at the length lands at the tail, then one in the middle
    send_beat(make_beat(OP_AT, 3, 0));
    send_beat(make_beat(OP_AT, 1, 32'h1234_5678));
    send_beat(make_beat(OP_AT, 6, 32'h0BAD_0BAD));
    send_beat(make_beat(OP_AT, 32767, 32'h0BAD_0BAD));
    // reads: first, last, one past, negative, both position extremes
    send_beat(make_beat(OP_READ, 0, 0));
    send_beat(make_beat(OP_READ, 4, 0));
    send_beat(make_beat(OP_READ, 5, 0));
    send_beat(make_beat(OP_READ, -1, 0));
    send_beat(make_beat(OP_READ, -32768, 0));
    send_beat(make_beat(OP_READ, 32767, 0));
    // opcodes with no meaning are ignored
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_beat(make_beat(3'(op), 0, $urandom));
    // deletes: out of range both sides, middle, tail, head
    send_beat(make_beat(OP_DELETE, -1, 0));
    send_beat(make_beat(OP_DELETE, 5, 0));
    send_beat(make_beat(OP_DELETE, 2, 0));
    send_beat(make_beat(OP_DELETE, 3, 0));
    send_beat(make_beat(OP_DELETE, 0, 0));
    send_beat(make_beat(OP_READ, 1, 0));
    wait_drained();

    // back-to-back beats against a long response hold
    long_hold_req = 1'b1;
    sender_odds = 0;
    repeat (PRESSURE_BEATS) send_beat(random_beat(LEAN_GROW, held_length));
    wait_drained();

    // random blocks: grow runs fill the store to capacity, shrink runs empty it
    for (int blk = 0; blk < 12; blk++) begin
      if (blk >= 10) begin
        quiet_tail = 1'b1;
        sender_odds = 0;
      end
      for (int n = 0; n < BLOCK_BEATS; n++) begin
        if (n % 20 == 0 && !quiet_tail) begin
          case ($urandom_range(0, 2))
            0:       sender_odds = 0;
            1:       sender_odds = 8;
            default: sender_odds = 3;
          endcase
        end
        maybe_gap();
        send_beat(random_beat(plan[blk], held_length));
      end
      if (blk == 5) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("checked %0d response beats in %0d cycles, %0d inserts refused by a full store",
             beats_checked, cycle_count, full_rejects);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ilid_pkg.sv
sv/ilid_cell.sv
sv/indexed_list_insert_delete_core.sv
bench/ilid_list_checker.sv
bench/indexed_list_insert_delete_core_test.sv
